### hdl/divisor_count_sieve_core_macros.svh
// Assertion macros for the divisor count sieve core.
// Used by files that include this header; expects clk and rst in scope.
`ifndef DIVISOR_COUNT_SIEVE_CORE_MACROS_SVH
`define DIVISOR_COUNT_SIEVE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dcs_pkg.sv
// Shared widths, codes and types for the divisor count sieve core.
// No dependencies; used by dcs_table and divisor_count_sieve_core.
`timescale 1ns / 1ps

package dcs_pkg;

  localparam int PosW        = 17;     // integer / limit width
  localparam int CntW        = 9;      // divisor count width
  localparam int StatW       = 2;
  localparam int MaxNDefault = 65536;
  localparam int TblDepthCap = 131071; // largest limit the 17-bit register can hold
  localparam int LimitReset  = 65536;

  localparam logic [CntW-1:0] CntSat = '1;

  localparam logic FUNC_BUILD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [StatW-1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_NOT_BUILT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_FILL,
    ST_SIEVE,
    ST_DRAIN
  } state_t;

endpackage

### hdl/dcs_table.sv
// Divisor count table: one-port-read, one-port-write synchronous memory.
// Read data registered; a read that hits the same-edge write is forwarded.
// Depends on dcs_pkg.
`timescale 1ns / 1ps

module dcs_table #(
  parameter int Depth = dcs_pkg::TblDepthCap,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [AddrW-1:0]          rd_addr,
  input  logic                      wr_en,
  input  logic [AddrW-1:0]          wr_addr,
  input  logic [dcs_pkg::CntW-1:0]  wr_data,
  output logic [dcs_pkg::CntW-1:0]  rd_data
);

  logic [dcs_pkg::CntW-1:0] mem [Depth];
  logic [dcs_pkg::CntW-1:0] mem_q;
  logic [dcs_pkg::CntW-1:0] fwd_data;
  logic                     fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
    fwd_data <= wr_data;
  end

  // memory returns the pre-write value on a same-address collision
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= rd_en && wr_en && (rd_addr == wr_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

### hdl/divisor_count_sieve_core.sv
// Divisor count sieve core. Query: a table read, then a registered result; the next
// query is taken only once back in idle. Build: a fill pass, then the sieve passes,
//   one table write per cycle through the single memory write port; input stalls.
// Reset: record, table-ready flag and built limit clear; limit register = 65536.
// Table contents are not cleared by reset; a build writes every entry it covers.
`timescale 1ns / 1ps
`include "divisor_count_sieve_core_macros.svh"

module divisor_count_sieve_core #(
  parameter int MAX_N = dcs_pkg::MaxNDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [dcs_pkg::PosW-1:0]   cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic [dcs_pkg::PosW-1:0]   number,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dcs_pkg::CntW-1:0]   divisor_count,
  output logic [dcs_pkg::CntW-1:0]   running_max,
  output logic [dcs_pkg::PosW-1:0]   max_at,
  output logic [dcs_pkg::StatW-1:0]  status
);

  localparam int PosW     = dcs_pkg::PosW;
  localparam int CntW     = dcs_pkg::CntW;
  localparam int TblDepth = (MAX_N < dcs_pkg::TblDepthCap) ? MAX_N : dcs_pkg::TblDepthCap;
  localparam int AddrW    = (TblDepth > 1) ? $clog2(TblDepth) : 1;
  localparam logic [PosW-1:0] LimCap = PosW'(TblDepth);

  dcs_pkg::state_t  state, state_next;
  dcs_pkg::status_t q_status, q_status_next;
  dcs_pkg::status_t out_stat, out_stat_next;

  logic [PosW-1:0] upper_limit;
  logic [PosW-1:0] built_limit, built_limit_next;
  logic            table_ready, table_ready_next;
  logic [CntW-1:0] record_count, record_count_next;
  logic [PosW-1:0] record_position, record_position_next;
  logic [PosW-1:0] d, d_next;
  logic [PosW-1:0] m, m_next;
  logic [PosW-1:0] q_num, q_num_next;
  logic            s1_valid, s1_valid_next;
  logic [AddrW-1:0] s1_addr, s1_addr_next;
  logic            out_valid_next;
  logic [CntW-1:0] out_cnt, out_cnt_next;
  logic [CntW-1:0] out_max, out_max_next;
  logic [PosW-1:0] out_at, out_at_next;

  logic             rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [CntW-1:0]  wr_data, rd_data, inc;
  logic [PosW-1:0]  lim_eff;
  logic [PosW:0]    m_plus_d, d_plus_one;
  logic             in_stall_c;

  dcs_table #(
    .Depth (TblDepth),
    .AddrW (AddrW)
  ) u_tbl (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign lim_eff    = (upper_limit > LimCap) ? LimCap : upper_limit;
  assign m_plus_d   = {1'b0, m} + {1'b0, d};
  assign d_plus_one = {1'b0, d} + (PosW+1)'(1);
  assign inc        = (rd_data == dcs_pkg::CntSat) ? dcs_pkg::CntSat : rd_data + CntW'(1);

  always_comb begin
    state_next           = state;
    q_status_next        = q_status;
    q_num_next           = q_num;
    built_limit_next     = built_limit;
    table_ready_next     = table_ready;
    record_count_next    = record_count;
    record_position_next = record_position;
    d_next               = d;
    m_next               = m;
    s1_valid_next        = 1'b0;
    s1_addr_next         = s1_addr;
    out_valid_next       = out_valid && out_stall;
    out_cnt_next         = out_cnt;
    out_max_next         = out_max;
    out_at_next          = out_at;
    out_stat_next        = out_stat;
    rd_en                = 1'b0;
    rd_addr              = AddrW'(m - PosW'(1));
    wr_en                = 1'b0;
    wr_addr              = s1_addr;
    wr_data              = inc;
    in_stall_c           = 1'b1;

    unique case (state)
      dcs_pkg::ST_IDLE: begin
        in_stall_c = out_valid && out_stall;
        if (in_valid && !in_stall_c) begin
          if (func == dcs_pkg::FUNC_BUILD) begin
            built_limit_next     = lim_eff;
            table_ready_next     = 1'b1;
            record_count_next    = '0;
            record_position_next = '0;
            d_next               = PosW'(1);
            m_next               = PosW'(1);
            state_next = (lim_eff == '0) ? dcs_pkg::ST_DRAIN : dcs_pkg::ST_FILL;
          end else begin
            q_num_next = number;
            if (!table_ready) begin
              q_status_next = dcs_pkg::STAT_NOT_BUILT;
            end else if (number == '0 || number > built_limit) begin
              q_status_next = dcs_pkg::STAT_RANGE;
            end else begin
              q_status_next = dcs_pkg::STAT_OK;
            end
            rd_en      = 1'b1;
            rd_addr    = AddrW'(number - PosW'(1));
            state_next = dcs_pkg::ST_QUERY;
          end
        end
      end

      dcs_pkg::ST_QUERY: begin
        out_cnt_next = '0;
        if (q_status == dcs_pkg::STAT_OK) begin
          out_cnt_next = rd_data;
          if (rd_data > record_count) begin
            record_count_next    = rd_data;
            record_position_next = q_num;
          end
        end
        out_valid_next = 1'b1;
        out_max_next   = record_count_next;
        out_at_next    = record_position_next;
        out_stat_next  = q_status;
        state_next     = dcs_pkg::ST_IDLE;
      end

      // divisor 1 hits every entry once: write 1 straight, no read needed
      dcs_pkg::ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = AddrW'(m - PosW'(1));
        wr_data = CntW'(1);
        if (m == built_limit) begin
          d_next     = PosW'(2);
          m_next     = PosW'(2);
          state_next = (built_limit < PosW'(2)) ? dcs_pkg::ST_DRAIN : dcs_pkg::ST_SIEVE;
        end else begin
          m_next = m + PosW'(1);
        end
      end

      // read m this cycle, write back the increment the cycle after
      dcs_pkg::ST_SIEVE: begin
        rd_en         = 1'b1;
        s1_valid_next = 1'b1;
        s1_addr_next  = rd_addr;
        wr_en         = s1_valid;
        if (m_plus_d > {1'b0, built_limit}) begin
          if (d_plus_one > {1'b0, built_limit}) begin
            state_next = dcs_pkg::ST_DRAIN;
          end else begin
            d_next = d_plus_one[PosW-1:0];
            m_next = d_plus_one[PosW-1:0];
          end
        end else begin
          m_next = m_plus_d[PosW-1:0];
        end
      end

      dcs_pkg::ST_DRAIN: begin
        wr_en          = s1_valid;
        out_valid_next = 1'b1;
        out_cnt_next   = '0;
        out_max_next   = '0;
        out_at_next    = '0;
        out_stat_next  = dcs_pkg::STAT_OK;
        state_next     = dcs_pkg::ST_IDLE;
      end

      default: begin
        state_next = dcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= dcs_pkg::ST_IDLE;
      upper_limit     <= PosW'(dcs_pkg::LimitReset);
      built_limit     <= '0;
      table_ready     <= 1'b0;
      record_count    <= '0;
      record_position <= '0;
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      built_limit     <= built_limit_next;
      table_ready     <= table_ready_next;
      record_count    <= record_count_next;
      record_position <= record_position_next;
      s1_valid        <= s1_valid_next;
      out_valid       <= out_valid_next;
      if (cfg_wr_en) begin
        upper_limit <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    d        <= d_next;
    m        <= m_next;
    q_num    <= q_num_next;
    q_status <= q_status_next;
    s1_addr  <= s1_addr_next;
    out_cnt  <= out_cnt_next;
    out_max  <= out_max_next;
    out_at   <= out_at_next;
    out_stat <= out_stat_next;
  end

  assign in_stall      = in_stall_c;
  assign divisor_count = out_cnt;
  assign running_max   = out_max;
  assign max_at        = out_at;
  assign status        = out_stat;

  `DCS_ASSERT_NOW(a_err_zero_count, out_valid && out_stat != dcs_pkg::STAT_OK, out_cnt == '0, "error beat carries a nonzero count")
  `DCS_ASSERT_NOW(a_count_within_max, out_valid && out_stat == dcs_pkg::STAT_OK, out_cnt <= out_max, "result count above running max")
  `DCS_ASSERT_NOW(a_no_wb_in_idle, state == dcs_pkg::ST_IDLE, !s1_valid, "table write pending while idle")
  `DCS_ASSERT_NOW(a_sieve_bounds, state == dcs_pkg::ST_SIEVE, m <= built_limit && d <= m, "sieve index outside built limit")
  `DCS_ASSERT_NEXT(a_query_reads, state == dcs_pkg::ST_IDLE && in_valid && !in_stall && func == dcs_pkg::FUNC_QUERY, state == dcs_pkg::ST_QUERY, "query beat did not start a table read")

endmodule
